@@ rtl/olb_pkg.sv @@
// Shared types and constants for the limited-depth order book.
// Used by the channel interfaces, the level cell, the book chain and the top level.
// Depends on nothing else.
package olb_pkg;

  // Default number of price levels held per side.
  localparam int unsigned LEVELS_DEFAULT = 20;

  // Payload field widths.
  localparam int unsigned FUNC_W    = 2;
  localparam int unsigned PRICE_W   = 32;
  localparam int unsigned VOLUME_W  = 32;
  localparam int unsigned OUTCOME_W = 3;
  localparam int unsigned LEVELS_W  = 5;

  // Function codes carried by an input item.
  localparam logic [FUNC_W-1:0] FUNC_LEVEL = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_TOP   = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_CLEAR = 2'd2;

  // Side codes.
  localparam logic SIDE_BID = 1'b0;
  localparam logic SIDE_ASK = 1'b1;

  // Outcome codes carried by a result item.
  localparam logic [OUTCOME_W-1:0] OUT_UPDATED  = 3'd0;
  localparam logic [OUTCOME_W-1:0] OUT_INSERTED = 3'd1;
  localparam logic [OUTCOME_W-1:0] OUT_DELETED  = 3'd2;
  localparam logic [OUTCOME_W-1:0] OUT_IGNORED  = 3'd3;
  localparam logic [OUTCOME_W-1:0] OUT_CLEARED  = 3'd4;

  // What every cell of one book does in the apply cycle.
  typedef enum logic [2:0] {
    ACT_HOLD,
    ACT_VOLUME,
    ACT_DELETE,
    ACT_SORTED,
    ACT_FRONT
  } act_t;

  // Control broadcast from the top level to every cell of a book.
  typedef struct packed {
    logic cmp_en;
    logic apply_en;
    act_t act;
  } cell_ctl_t;

endpackage

@@ rtl/olb_if.sv @@
// Valid/ready channel interfaces for order book updates and their results.
// Depends on olb_pkg for the field widths.
interface olb_item_if;
  logic                           valid;
  logic                           ready;
  logic [olb_pkg::FUNC_W-1:0]     func;
  logic                           side;
  logic [olb_pkg::PRICE_W-1:0]    price;
  logic [olb_pkg::VOLUME_W-1:0]   volume;

  modport source (output valid, func, side, price, volume, input ready);
  modport sink   (input valid, func, side, price, volume, output ready);
endinterface

interface olb_result_if;
  logic                           valid;
  logic                           ready;
  logic [olb_pkg::OUTCOME_W-1:0]  outcome;
  logic                           dropped;
  logic [olb_pkg::PRICE_W-1:0]    best_bid_price;
  logic [olb_pkg::VOLUME_W-1:0]   best_bid_volume;
  logic [olb_pkg::PRICE_W-1:0]    best_ask_price;
  logic [olb_pkg::VOLUME_W-1:0]   best_ask_volume;
  logic [olb_pkg::LEVELS_W-1:0]   bid_levels;
  logic [olb_pkg::LEVELS_W-1:0]   ask_levels;

  modport source (output valid, outcome, dropped, best_bid_price, best_bid_volume,
                  best_ask_price, best_ask_volume, bid_levels, ask_levels,
                  input ready);
  modport sink   (input valid, outcome, dropped, best_bid_price, best_bid_volume,
                  best_ask_price, best_ask_volume, bid_levels, ask_levels,
                  output ready);
endinterface

@@ rtl/olb_cell.sv @@
// One price level of a book: stored price and volume, compare flags and shift logic.
// Depends on olb_pkg for the control struct and action codes.
module olb_cell #(
  parameter int unsigned INDEX = 0,
  parameter int unsigned CW    = 5,
  parameter bit          ASK   = 1'b0
) (
  input  logic                          clk,
  input  olb_pkg::cell_ctl_t            ctl,
  input  logic [CW-1:0]                 count,
  input  logic [olb_pkg::PRICE_W-1:0]   cmp_price,
  input  logic [olb_pkg::PRICE_W-1:0]   new_price,
  input  logic [olb_pkg::VOLUME_W-1:0]  new_volume,
  input  logic [olb_pkg::PRICE_W-1:0]   left_price,
  input  logic [olb_pkg::VOLUME_W-1:0]  left_volume,
  input  logic [olb_pkg::PRICE_W-1:0]   right_price,
  input  logic [olb_pkg::VOLUME_W-1:0]  right_volume,
  input  logic                          hit_in,
  input  logic                          worse_in,
  input  logic                          at_after_in,
  output logic [olb_pkg::PRICE_W-1:0]   price,
  output logic [olb_pkg::VOLUME_W-1:0]  volume,
  output logic [olb_pkg::PRICE_W-1:0]   price_next,
  output logic [olb_pkg::VOLUME_W-1:0]  volume_next,
  output logic                          hit_out,
  output logic                          worse_out,
  output logic                          at_after_out
);

  logic live;
  logic hit;
  logic worse;
  logic live_cmp;

  // Compare cycle: flag an exact price match and a worse level among valid entries.
  assign live_cmp = (CW'(INDEX) < count);

  always_ff @(posedge clk) begin
    if (ctl.cmp_en) begin
      live  <= live_cmp;
      hit   <= live_cmp && (price == cmp_price);
      worse <= live_cmp && (ASK ? (price > cmp_price) : (price < cmp_price));
    end
  end

  // Prefix flags handed down the chain towards the back of the book.
  assign hit_out      = hit_in | hit;
  assign worse_out    = worse_in | worse;
  assign at_after_out = (ctl.act == olb_pkg::ACT_FRONT) || worse_out || !live;

  // Apply cycle: hold, take a neighbour's level, write a new volume, or write the new level.
  always_comb begin
    price_next  = price;
    volume_next = volume;
    case (ctl.act)
      olb_pkg::ACT_VOLUME: begin
        if (hit && !hit_in) begin
          volume_next = new_volume;
        end
      end
      olb_pkg::ACT_DELETE: begin
        if (hit_out) begin
          price_next  = right_price;
          volume_next = right_volume;
        end
      end
      olb_pkg::ACT_SORTED, olb_pkg::ACT_FRONT: begin
        if (at_after_in) begin
          price_next  = left_price;
          volume_next = left_volume;
        end else if (at_after_out) begin
          price_next  = new_price;
          volume_next = new_volume;
        end
      end
      default: begin
        price_next  = price;
        volume_next = volume;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (ctl.apply_en) begin
      price  <= price_next;
      volume <= volume_next;
    end
  end

endmodule

@@ rtl/olb_book.sv @@
// One side of the order book: a chain of level cells, best level at the front.
// Depends on olb_pkg and olb_cell.
module olb_book #(
  parameter int unsigned LEVELS = olb_pkg::LEVELS_DEFAULT,
  parameter int unsigned CW     = $clog2(LEVELS + 1),
  parameter bit          ASK    = 1'b0
) (
  input  logic                          clk,
  input  olb_pkg::cell_ctl_t            ctl,
  input  logic [CW-1:0]                 count,
  input  logic [olb_pkg::PRICE_W-1:0]   cmp_price,
  input  logic [olb_pkg::PRICE_W-1:0]   new_price,
  input  logic [olb_pkg::VOLUME_W-1:0]  new_volume,
  output logic                          any_hit,
  output logic [olb_pkg::PRICE_W-1:0]   head_price_next,
  output logic [olb_pkg::VOLUME_W-1:0]  head_volume_next
);

  logic [olb_pkg::PRICE_W-1:0]  price_w      [LEVELS];
  logic [olb_pkg::VOLUME_W-1:0] volume_w     [LEVELS];
  logic [olb_pkg::PRICE_W-1:0]  price_next_w [LEVELS];
  logic [olb_pkg::VOLUME_W-1:0] volume_next_w[LEVELS];
  logic [olb_pkg::PRICE_W-1:0]  left_price   [LEVELS];
  logic [olb_pkg::VOLUME_W-1:0] left_volume  [LEVELS];
  logic [olb_pkg::PRICE_W-1:0]  right_price  [LEVELS];
  logic [olb_pkg::VOLUME_W-1:0] right_volume [LEVELS];
  logic [LEVELS:0]              hit_chain;
  logic [LEVELS:0]              worse_chain;
  logic [LEVELS:0]              at_after_chain;

  // Nothing lies in front of the first cell.
  assign hit_chain[0]      = 1'b0;
  assign worse_chain[0]    = 1'b0;
  assign at_after_chain[0] = 1'b0;

  for (genvar i = 0; i < LEVELS; i++) begin : g_cell
    // Neighbour links; the ends of the chain see the new level or zero.
    if (i == 0) begin : g_head
      assign left_price[i]  = new_price;
      assign left_volume[i] = new_volume;
    end else begin : g_mid_left
      assign left_price[i]  = price_w[i-1];
      assign left_volume[i] = volume_w[i-1];
    end
    if (i == LEVELS - 1) begin : g_tail
      assign right_price[i]  = '0;
      assign right_volume[i] = '0;
    end else begin : g_mid_right
      assign right_price[i]  = price_w[i+1];
      assign right_volume[i] = volume_w[i+1];
    end

    olb_cell #(
      .INDEX (i),
      .CW    (CW),
      .ASK   (ASK)
    ) u_cell (
      .clk          (clk),
      .ctl          (ctl),
      .count        (count),
      .cmp_price    (cmp_price),
      .new_price    (new_price),
      .new_volume   (new_volume),
      .left_price   (left_price[i]),
      .left_volume  (left_volume[i]),
      .right_price  (right_price[i]),
      .right_volume (right_volume[i]),
      .hit_in       (hit_chain[i]),
      .worse_in     (worse_chain[i]),
      .at_after_in  (at_after_chain[i]),
      .price        (price_w[i]),
      .volume       (volume_w[i]),
      .price_next   (price_next_w[i]),
      .volume_next  (volume_next_w[i]),
      .hit_out      (hit_chain[i+1]),
      .worse_out    (worse_chain[i+1]),
      .at_after_out (at_after_chain[i+1])
    );
  end

  // A match anywhere in the book, and the front level after this update.
  assign any_hit          = hit_chain[LEVELS];
  assign head_price_next  = price_next_w[0];
  assign head_volume_next = volume_next_w[0];

endmodule

@@ rtl/limited_depth_order_book.sv @@
// Limited-depth price-level order book, bid and ask sides as chains of level cells.
// Sequencing: the compare registers match flags on the item transfer edge; the apply,
// which waits for a free result register, updates the cells and loads the result register.
// A new item is taken only after the last one is applied, as the compare and apply cycles
// share the cell chain; a stalled result holds the apply cycle until it is taken.
// Reset clears both level counts and the channel state; stored levels need no clearing.
// Depends on olb_pkg, olb_if and olb_book.
module limited_depth_order_book #(
  parameter int unsigned LEVELS = olb_pkg::LEVELS_DEFAULT
) (
  input  logic                clk,
  input  logic                rst,
  olb_item_if.sink            item,
  olb_result_if.source        result
);

  localparam int unsigned CW = $clog2(LEVELS + 1);

  // Captured item and sequencing.
  logic                           busy;
  logic [olb_pkg::FUNC_W-1:0]     op_func;
  logic                           op_side;
  logic [olb_pkg::PRICE_W-1:0]    op_price;
  logic [olb_pkg::VOLUME_W-1:0]   op_volume;
  logic [CW-1:0]                  bid_count;
  logic [CW-1:0]                  ask_count;
  logic [CW-1:0]                  bid_count_next;
  logic [CW-1:0]                  ask_count_next;
  logic                           item_xfer;
  logic                           apply_en;

  // Book connections.
  olb_pkg::cell_ctl_t             bid_ctl;
  olb_pkg::cell_ctl_t             ask_ctl;
  logic                           bid_hit;
  logic                           ask_hit;
  logic [olb_pkg::PRICE_W-1:0]    bid_head_price;
  logic [olb_pkg::VOLUME_W-1:0]   bid_head_volume;
  logic [olb_pkg::PRICE_W-1:0]    ask_head_price;
  logic [olb_pkg::VOLUME_W-1:0]   ask_head_volume;

  // Decision for the selected side.
  olb_pkg::act_t                  act_sel;
  logic [olb_pkg::OUTCOME_W-1:0]  outcome_next;
  logic                           dropped_next;
  logic                           any_hit;
  logic [CW-1:0]                  sel_count;
  logic [CW-1:0]                  sel_count_next;
  logic                           full;
  logic                           clear_all;
  logic [CW+olb_pkg::LEVELS_W-1:0] bid_levels_ext;
  logic [CW+olb_pkg::LEVELS_W-1:0] ask_levels_ext;

  // Handshake: one item in flight; the apply cycle waits for a free result register.
  assign item.ready = !busy && !rst;
  assign item_xfer  = item.valid && item.ready;
  assign apply_en   = busy && (!result.valid || result.ready);

  always_ff @(posedge clk) begin
    if (item_xfer) begin
      op_func   <= item.func;
      op_side   <= item.side;
      op_price  <= item.price;
      op_volume <= item.volume;
    end
  end

  // Work out the action, outcome and new count from the match flags.
  assign any_hit   = (op_side == olb_pkg::SIDE_ASK) ? ask_hit : bid_hit;
  assign sel_count = (op_side == olb_pkg::SIDE_ASK) ? ask_count : bid_count;
  assign full      = (sel_count == CW'(LEVELS));

  always_comb begin
    act_sel        = olb_pkg::ACT_HOLD;
    outcome_next   = olb_pkg::OUT_IGNORED;
    dropped_next   = 1'b0;
    sel_count_next = sel_count;
    clear_all      = 1'b0;
    unique case (op_func)
      olb_pkg::FUNC_LEVEL: begin
        if (any_hit) begin
          if (op_volume == '0) begin
            act_sel        = olb_pkg::ACT_DELETE;
            outcome_next   = olb_pkg::OUT_DELETED;
            sel_count_next = sel_count - CW'(1);
          end else begin
            act_sel      = olb_pkg::ACT_VOLUME;
            outcome_next = olb_pkg::OUT_UPDATED;
          end
        end else if (op_volume != '0) begin
          act_sel        = olb_pkg::ACT_SORTED;
          outcome_next   = olb_pkg::OUT_INSERTED;
          dropped_next   = full;
          sel_count_next = full ? sel_count : sel_count + CW'(1);
        end
      end
      olb_pkg::FUNC_TOP: begin
        if (any_hit) begin
          act_sel      = olb_pkg::ACT_VOLUME;
          outcome_next = olb_pkg::OUT_UPDATED;
        end else begin
          act_sel        = olb_pkg::ACT_FRONT;
          outcome_next   = olb_pkg::OUT_INSERTED;
          dropped_next   = full;
          sel_count_next = full ? sel_count : sel_count + CW'(1);
        end
      end
      olb_pkg::FUNC_CLEAR: begin
        outcome_next = olb_pkg::OUT_CLEARED;
        clear_all    = 1'b1;
      end
      default: begin
        outcome_next = olb_pkg::OUT_IGNORED;
      end
    endcase
  end

  // Only the addressed book acts; a clear zeroes both counts.
  always_comb begin
    bid_ctl.cmp_en   = item_xfer;
    bid_ctl.apply_en = apply_en;
    bid_ctl.act      = (op_side == olb_pkg::SIDE_BID) ? act_sel : olb_pkg::ACT_HOLD;
    ask_ctl.cmp_en   = item_xfer;
    ask_ctl.apply_en = apply_en;
    ask_ctl.act      = (op_side == olb_pkg::SIDE_ASK) ? act_sel : olb_pkg::ACT_HOLD;
    bid_count_next   = bid_count;
    ask_count_next   = ask_count;
    if (clear_all) begin
      bid_count_next = '0;
      ask_count_next = '0;
    end else if (op_side == olb_pkg::SIDE_ASK) begin
      ask_count_next = sel_count_next;
    end else begin
      bid_count_next = sel_count_next;
    end
  end

  olb_book #(
    .LEVELS (LEVELS),
    .CW     (CW),
    .ASK    (1'b0)
  ) u_bid_book (
    .clk              (clk),
    .ctl              (bid_ctl),
    .count            (bid_count),
    .cmp_price        (item.price),
    .new_price        (op_price),
    .new_volume       (op_volume),
    .any_hit          (bid_hit),
    .head_price_next  (bid_head_price),
    .head_volume_next (bid_head_volume)
  );

  olb_book #(
    .LEVELS (LEVELS),
    .CW     (CW),
    .ASK    (1'b1)
  ) u_ask_book (
    .clk              (clk),
    .ctl              (ask_ctl),
    .count            (ask_count),
    .cmp_price        (item.price),
    .new_price        (op_price),
    .new_volume       (op_volume),
    .any_hit          (ask_hit),
    .head_price_next  (ask_head_price),
    .head_volume_next (ask_head_volume)
  );

  // Level counts reported modulo the field width.
  assign bid_levels_ext = {{olb_pkg::LEVELS_W{1'b0}}, bid_count_next};
  assign ask_levels_ext = {{olb_pkg::LEVELS_W{1'b0}}, ask_count_next};

  // Control state: sequencing, counts and result valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy         <= 1'b0;
      bid_count    <= '0;
      ask_count    <= '0;
      result.valid <= 1'b0;
    end else begin
      if (item_xfer) begin
        busy <= 1'b1;
      end else if (apply_en) begin
        busy <= 1'b0;
      end
      if (apply_en) begin
        bid_count    <= bid_count_next;
        ask_count    <= ask_count_next;
        result.valid <= 1'b1;
      end else if (result.ready) begin
        result.valid <= 1'b0;
      end
    end
  end

  // Result payload, loaded with the book fronts after the update.
  always_ff @(posedge clk) begin
    if (apply_en) begin
      result.outcome         <= outcome_next;
      result.dropped         <= dropped_next;
      result.best_bid_price  <= (bid_count_next != '0) ? bid_head_price : '0;
      result.best_bid_volume <= (bid_count_next != '0) ? bid_head_volume : '0;
      result.best_ask_price  <= (ask_count_next != '0) ? ask_head_price : '0;
      result.best_ask_volume <= (ask_count_next != '0) ? ask_head_volume : '0;
      result.bid_levels      <= bid_levels_ext[olb_pkg::LEVELS_W-1:0];
      result.ask_levels      <= ask_levels_ext[olb_pkg::LEVELS_W-1:0];
    end
  end

  // A transfer is followed by its apply cycle before the next transfer.
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    (item.valid && item.ready) |=> !item.ready)
    else $error("item taken while another is in flight");

  // The level counts never pass the book depth.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    (bid_count <= CW'(LEVELS)) && (ask_count <= CW'(LEVELS)))
    else $error("level count beyond book depth");

  // A new result only appears after an apply cycle.
  a_result_after_apply: assert property (@(posedge clk) disable iff (rst)
    $rose(result.valid) |-> $past(busy))
    else $error("result without a preceding apply cycle");

  // Only an insertion can push a level off the end.
  a_drop_on_insert: assert property (@(posedge clk) disable iff (rst)
    (result.valid && result.dropped) |-> (result.outcome == olb_pkg::OUT_INSERTED))
    else $error("dropped level without an insertion");

endmodule
